### rtl/strongest_signal_tracker_core_defines.svh
// Assertion macros shared by the strongest signal tracker RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef STRONGEST_SIGNAL_TRACKER_CORE_DEFINES_SVH
`define STRONGEST_SIGNAL_TRACKER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication check
`define SST_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sst: same-cycle property violated");
// Next-cycle implication check
`define SST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sst: next-cycle property violated");
`else
`define SST_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/sst_pkg.sv
// Shared types and constants of the strongest signal tracker.
// No dependencies; used by the interfaces, the cells, the control and the top level.
package sst_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 8;
  localparam int TYPE_W  = 2;
  localparam int ID_W    = 8;
  localparam int RSSI_W  = 8;
  localparam int COUNT_W = 8;
  localparam int SLOT_W  = 6;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ADD   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_UPDATE,
    CELL_CLEAR,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ctrl_state_t;

  // Broadcast command to every cell
  typedef struct packed {
    cell_op_t            op;
    logic [ID_W-1:0]     new_id;
    logic [RSSI_W-1:0]   new_rssi;
  } cell_ctrl_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [RSSI_W-1:0]   rssi;
  } cell_data_t;

  // What a cell shows its neighbors
  typedef struct packed {
    cell_data_t          data;
    logic                ahead;
  } cell_link_t;

endpackage

### rtl/sst_req_if.sv
// Request channel of the strongest signal tracker: valid/ready plus request fields.
// Depends on sst_pkg for field widths.
interface sst_req_if;
  logic                          valid;
  logic                          ready;
  logic [sst_pkg::TYPE_W-1:0]    req_type;
  logic [sst_pkg::ID_W-1:0]      node_id;
  logic [sst_pkg::RSSI_W-1:0]    rssi;
  logic [sst_pkg::COUNT_W-1:0]   read_count;

  modport source (output valid, req_type, node_id, rssi, read_count, input ready);
  modport sink (input valid, req_type, node_id, rssi, read_count, output ready);
endinterface

### rtl/sst_rsp_if.sv
// Result channel of the strongest signal tracker: valid/ready plus slot fields.
// Depends on sst_pkg for field widths.
interface sst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sst_pkg::ID_W-1:0]      entry_id;
  logic [sst_pkg::RSSI_W-1:0]    entry_rssi;
  logic [sst_pkg::SLOT_W-1:0]    slot_index;
  logic                          last;

  modport source (output valid, entry_id, entry_rssi, slot_index, last, input ready);
  modport sink (input valid, entry_id, entry_rssi, slot_index, last, output ready);
endinterface

### rtl/sst_cell.sv
// One slot of the sorted table: holds an id and a signal value, and picks its
// next contents from itself, its neighbors or the new request. Depends on sst_pkg.
module sst_cell (
  input  logic                clk,
  input  logic                rst,
  input  sst_pkg::cell_ctrl_t ctl,
  input  sst_pkg::cell_link_t left,
  input  sst_pkg::cell_link_t right,
  input  logic                seen,
  output sst_pkg::cell_link_t link,
  output logic                match
);

  sst_pkg::cell_data_t slot;
  sst_pkg::cell_data_t slot_next;
  sst_pkg::cell_data_t fresh;
  logic                valid;
  logic                lt;
  logic                le;
  logic                ahead;

  // Compare own entry against the new request
  assign valid  = (slot.rssi != '0);
  assign match  = valid && (slot.id == ctl.new_id);
  assign lt     = valid && (slot.rssi < ctl.new_rssi);
  assign le     = valid && (slot.rssi <= ctl.new_rssi);
  // Entry stays ahead of the new one; the matched entry itself leaves the list
  assign ahead  = match ? 1'b0 : (seen ? lt : le);
  assign fresh  = '{id: ctl.new_id, rssi: ctl.new_rssi};

  assign link = '{data: slot, ahead: ahead};

  // Select next contents
  always_comb begin
    slot_next = slot;
    case (ctl.op)
      sst_pkg::CELL_CLEAR:  slot_next = '0;
      sst_pkg::CELL_ROTATE: slot_next = right.data;
      sst_pkg::CELL_UPDATE: begin
        if (!seen && !match) begin
          // ahead of any matched entry: insert shifts down
          if (ahead) begin
            slot_next = slot;
          end else if (left.ahead) begin
            slot_next = fresh;
          end else begin
            slot_next = left.data;
          end
        end else if (match) begin
          if (right.ahead) begin
            slot_next = right.data;
          end else if (left.ahead) begin
            slot_next = fresh;
          end else begin
            slot_next = left.data;
          end
        end else begin
          // behind the matched entry: close the gap upward
          if (right.ahead) begin
            slot_next = right.data;
          end else if (ahead) begin
            slot_next = fresh;
          end else begin
            slot_next = slot;
          end
        end
      end
      default: slot_next = slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule

### rtl/sst_ctrl.sv
// Request decoder, read sequencer and output register of the tracker.
// Depends on sst_pkg, sst_req_if, sst_rsp_if and the assertion macro header.
`include "strongest_signal_tracker_core_defines.svh"
module sst_ctrl #(
  parameter int TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  sst_req_if.sink             req,
  sst_rsp_if.source           rsp,
  input  sst_pkg::cell_data_t head,
  output sst_pkg::cell_ctrl_t cell_ctl
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(TABLE_DEPTH - 1);

  sst_pkg::ctrl_state_t        state;
  sst_pkg::ctrl_state_t        state_next;
  logic [IDX_W-1:0]            cnt;
  logic [CNT_W-1:0]            want;
  logic [CNT_W-1:0]            want_next;
  logic [CNT_W-1:0]            cnt_ext;
  logic                        accept;
  logic                        is_read;
  logic                        emitting;
  logic                        out_free;
  logic                        advance;
  logic                        load;
  logic                        rsp_valid_q;
  sst_pkg::cell_data_t         rsp_data_q;
  logic [sst_pkg::SLOT_W-1:0]  rsp_slot_q;
  logic                        rsp_last_q;

  // Request handshake and read length
  assign req.ready = (state == sst_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign is_read   = (req.req_type == sst_pkg::REQ_READ);
  assign want_next = (req.read_count >= 8'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                         : CNT_W'(req.read_count);

  // Read sequencing: the ring turns one slot per step, emitting while cnt < want
  assign cnt_ext  = CNT_W'(cnt);
  assign emitting = (cnt_ext < want);
  assign out_free = !rsp_valid_q || rsp.ready;
  assign advance  = (state == sst_pkg::ST_READ) && (!emitting || out_free);
  assign load     = (state == sst_pkg::ST_READ) && emitting && out_free;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sst_pkg::ST_IDLE: begin
        if (accept && is_read && (want_next != '0)) begin
          state_next = sst_pkg::ST_READ;
        end
      end
      sst_pkg::ST_READ: begin
        if (advance && (cnt == CNT_LAST)) begin
          state_next = sst_pkg::ST_IDLE;
        end
      end
      default: state_next = sst_pkg::ST_IDLE;
    endcase
  end

  // Cell command
  always_comb begin
    cell_ctl.op       = sst_pkg::CELL_HOLD;
    cell_ctl.new_id   = req.node_id;
    cell_ctl.new_rssi = req.rssi;
    unique case (state)
      sst_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req.req_type)
            sst_pkg::REQ_ADD: begin
              if (req.rssi != '0) begin
                cell_ctl.op = sst_pkg::CELL_UPDATE;
              end
            end
            sst_pkg::REQ_CLEAR: cell_ctl.op = sst_pkg::CELL_CLEAR;
            default:            cell_ctl.op = sst_pkg::CELL_HOLD;
          endcase
        end
      end
      sst_pkg::ST_READ: begin
        if (advance) begin
          cell_ctl.op = sst_pkg::CELL_ROTATE;
        end
      end
      default: cell_ctl.op = sst_pkg::CELL_HOLD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sst_pkg::ST_IDLE;
      cnt   <= '0;
      want  <= '0;
    end else begin
      state <= state_next;
      if (accept && is_read) begin
        want <= want_next;
      end
      if (advance) begin
        cnt <= (cnt == CNT_LAST) ? '0 : cnt + 1'b1;
      end
    end
  end

  // Output register: hold a result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else if (load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_data_q <= head;
      rsp_slot_q <= sst_pkg::SLOT_W'(cnt);
      rsp_last_q <= (cnt_ext == want - CNT_W'(1));
    end
  end

  assign rsp.valid      = rsp_valid_q;
  assign rsp.entry_id   = rsp_data_q.id;
  assign rsp.entry_rssi = rsp_data_q.rssi;
  assign rsp.slot_index = rsp_slot_q;
  assign rsp.last       = rsp_last_q;

  `SST_ASSERT_IMPLY(a_idle_cnt_zero, clk, rst, state == sst_pkg::ST_IDLE, cnt == '0)
  `SST_ASSERT_NEXT(a_ring_done_idle, clk, rst, advance && (cnt == CNT_LAST), state == sst_pkg::ST_IDLE)
  `SST_ASSERT_IMPLY(a_load_rotates, clk, rst, load, cell_ctl.op == sst_pkg::CELL_ROTATE)
  `SST_ASSERT_NEXT(a_load_shows, clk, rst, load, rsp_valid_q)
  `SST_ASSERT_IMPLY(a_idle_no_rotate, clk, rst, state == sst_pkg::ST_IDLE, cell_ctl.op != sst_pkg::CELL_ROTATE)

endmodule

### rtl/strongest_signal_tracker_core.sv
// Top level of the strongest signal tracker: a ring of sorted table cells and
// the control. Depends on sst_pkg, sst_req_if, sst_rsp_if, sst_cell and sst_ctrl.
//
//  port  role     fields
//  req   sink     req_type, node_id, rssi, read_count
//  rsp   source   entry_id, entry_rssi, slot_index, last
//
// In add and clear requests every cell compares and shifts at once.
// A read turns the cell ring TABLE_DEPTH steps, and no new request is taken
// until it ends; a step waits while rsp stalls a pending slot. A read of zero
// slots turns no cell and returns no slot.
// Synchronous reset empties every cell at once; no clearing pass.
module strongest_signal_tracker_core #(
  parameter int TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  sst_req_if.sink   req,
  sst_rsp_if.source rsp
);

  sst_pkg::cell_ctrl_t cell_ctl;
  sst_pkg::cell_link_t link  [TABLE_DEPTH];
  logic                match [TABLE_DEPTH];
  logic                seen  [TABLE_DEPTH];

  // Ripple the matched-entry mark down the row
  assign seen[0] = 1'b0;
  for (genvar k = 0; k < TABLE_DEPTH - 1; k++) begin : g_seen
    assign seen[k+1] = seen[k] | match[k];
  end

  // Row of cells; the tail wraps to the head for read rotation
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    sst_pkg::cell_link_t lft;
    sst_pkg::cell_link_t rgt;

    if (k == 0) begin : g_head
      assign lft = '{data: '0, ahead: 1'b1};
    end else begin : g_mid_l
      assign lft = link[k-1];
    end

    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign rgt = '{data: link[0].data, ahead: 1'b0};
    end else begin : g_mid_r
      assign rgt = link[k+1];
    end

    sst_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (cell_ctl),
      .left  (lft),
      .right (rgt),
      .seen  (seen[k]),
      .link  (link[k]),
      .match (match[k])
    );
  end

  sst_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .head     (link[0].data),
    .cell_ctl (cell_ctl)
  );

endmodule
